@@ design/tccs_pkg.sv @@
package tccs_pkg;

   // Port widths of the request, response and control channels.
   localparam int TYPE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int OFFSET_W = 11;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_HOME  = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

@@ design/text_console_cursor_scroll.sv @@
// Home, read, carriage return and any put that does not scroll give their result in the
// cycle after acceptance, and busy stays low, so such a request can be taken every cycle.
// A put that scrolls holds busy for one pass over the store on its single read and single
// write port, and a clear holds busy for one pass as well; the result word is shown in the
// first cycle with busy low.
// Reset homes the cursor and sets the fill attribute to 7; the store is not cleared by reset.
module text_console_cursor_scroll #(
   parameter int ROW_COUNT = 25,
   parameter int COL_COUNT = 80
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [tccs_pkg::TYPE_W-1:0]     req_type,
   input  logic [tccs_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tccs_pkg::INDEX_W-1:0]    req_cell_index,
   // Response channel; the receiver takes every word in the cycle it is shown.
   output logic                            rsp_strobe,
   output logic [tccs_pkg::OFFSET_W-1:0]   rsp_cursor_offset,
   output logic [tccs_pkg::ROW_W-1:0]      rsp_cursor_row,
   output logic [tccs_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic                            rsp_scrolled,
   output logic [tccs_pkg::CHAR_W-1:0]     rsp_cell_char,
   output logic [tccs_pkg::ATTR_W-1:0]     rsp_cell_attr,
   // Fill attribute register write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tccs_pkg::ATTR_W-1:0]     csr_data
);

   import tccs_pkg::*;

   // The store is one linear array of ROW_COUNT*COL_COUNT cells, row-major, each cell
   // holding the attribute in the high byte and the character in the low byte.
   localparam int CELL_TOTAL = ROW_COUNT * COL_COUNT;
   localparam int AW  = $clog2(CELL_TOTAL);      // cell address width
   localparam int CW  = $clog2(CELL_TOTAL + 1);  // walk counter and cursor offset width
   localparam int RW  = $clog2(ROW_COUNT);
   localparam int CLW = $clog2(COL_COUNT);

   localparam logic [CW-1:0]  COLS_C    = CW'(COL_COUNT);
   localparam logic [CW-1:0]  MOVE_CNT  = CW'((ROW_COUNT - 1) * COL_COUNT);
   localparam logic [CW-1:0]  CELL_END  = CW'(CELL_TOTAL);
   localparam logic [RW-1:0]  LAST_ROW  = RW'(ROW_COUNT - 1);
   localparam logic [CLW-1:0] LAST_COL  = CLW'(COL_COUNT - 1);

   logic [CELL_W-1:0] cell_mem [CELL_TOTAL];

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               moving_ff, moving_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CLW-1:0]     col_ff, col_in;
   logic [CW-1:0]      off_ff, off_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic               strobe_ff, strobe_in;
   logic               scrolled_ff, scrolled_in;
   logic               rdok_ff, rdok_in;
   logic [CELL_W-1:0]  rd_data_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [CELL_W-1:0]  wr_data;
   logic [AW-1:0]      rd_addr;
   logic               go_scroll;
   req_kind_type       req_kind;

   logic [CW-1:0]         cnt_prev;
   logic [CW-1:0]         cnt_src;
   logic [CW+INDEX_W-1:0] idx_wide;
   logic [CW+INDEX_W-1:0] total_wide;
   logic                  idx_ok;
   logic [CELL_W-1:0]     blank_cell;

   assign req_kind   = req_kind_type'(req_type);
   assign cnt_prev   = cnt_ff - CW'(1);
   assign cnt_src    = cnt_ff + COLS_C;
   assign idx_wide   = {{CW{1'b0}}, req_cell_index};
   assign total_wide = {{INDEX_W{1'b0}}, CELL_END};
   assign idx_ok     = idx_wide < total_wide;
   assign blank_cell = {attr_ff, CHAR_BLANK};

   // Never stalls; software writes it only while the block is quiet, an unenforced rule.
   assign csr_ready = 1'b1;

   // Next-state and datapath control. In the idle state a request is handled in its
   // acceptance cycle: a character goes straight to the write port and a cell read goes
   // to the read port. Scroll and clear both become a walk over the store.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      moving_in   = moving_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      off_in      = off_ff;
      strobe_in   = 1'b0;
      scrolled_in = scrolled_ff;
      rdok_in     = rdok_ff;
      go_scroll   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = blank_cell;
      rd_addr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in   = 1'b1;
               scrolled_in = 1'b0;
               rdok_in     = 1'b0;
               case (req_kind)
                  REQ_PUT: begin
                     if (req_char_code == CHAR_CR) begin
                        col_in = '0;
                        off_in = off_ff - CW'(col_ff);
                     end else if (req_char_code == CHAR_LF) begin
                        // On the last row the row stays put and the screen moves instead,
                        // so the linear offset is unchanged.
                        if (row_ff == LAST_ROW) begin
                           go_scroll = 1'b1;
                        end else begin
                           row_in = row_ff + RW'(1);
                           off_in = off_ff + COLS_C;
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = off_ff[AW-1:0];
                        wr_data = {attr_ff, req_char_code};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           if (row_ff == LAST_ROW) begin
                              go_scroll = 1'b1;
                              off_in    = off_ff + CW'(1) - COLS_C;
                           end else begin
                              row_in = row_ff + RW'(1);
                              off_in = off_ff + CW'(1);
                           end
                        end else begin
                           col_in = col_ff + CLW'(1);
                           off_in = off_ff + CW'(1);
                        end
                     end
                     if (go_scroll) begin
                        strobe_in   = 1'b0;
                        scrolled_in = 1'b1;
                        state_in    = ST_WALK;
                        moving_in   = 1'b1;
                        cnt_in      = '0;
                     end
                  end
                  REQ_CLEAR: begin
                     strobe_in = 1'b0;
                     state_in  = ST_WALK;
                     moving_in = 1'b0;
                     cnt_in    = CW'(1);
                     row_in    = '0;
                     col_in    = '0;
                     off_in    = '0;
                  end
                  REQ_HOME: begin
                     row_in = '0;
                     col_in = '0;
                     off_in = '0;
                  end
                  REQ_READ: begin
                     rdok_in = idx_ok;
                     if (idx_ok) begin
                        rd_addr = idx_wide[AW-1:0];
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Step n reads cell n+COL_COUNT and writes cell n-1 with what step n-1 read,
            // so every write trails the reads and never lands on a cell still to be read.
            // Past the moved region, and for a clear, the written cell is a blank.
            if (moving_ff && (cnt_ff < MOVE_CNT)) begin
               rd_addr = cnt_src[AW-1:0];
            end
            wr_en   = (cnt_ff != '0);
            wr_addr = cnt_prev[AW-1:0];
            if (moving_ff && (cnt_ff <= MOVE_CNT)) begin
               wr_data = rd_data_ff;
            end
            if (cnt_ff == CELL_END) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      attr_in = attr_ff;
      if (csr_valid && csr_ready) begin
         attr_in = csr_data;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Cursor, attribute and response control.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         off_ff    <= '0;
         attr_ff   <= ATTR_RESET;
         strobe_ff <= 1'b0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         off_ff    <= off_in;
         attr_ff   <= attr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Walk counter and response flags only matter once a request has set them.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      moving_ff   <= moving_in;
      scrolled_ff <= scrolled_in;
      rdok_ff     <= rdok_in;
   end

   // Character store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= cell_mem[rd_addr];
   end

   // The response fields come straight from the cursor registers, which stay fixed
   // between the request and its response word.
   logic [CW+OFFSET_W-1:0] off_ext;
   logic [RW+ROW_W-1:0]    row_ext;
   logic [CLW+COL_W-1:0]   col_ext;

   assign off_ext = {{OFFSET_W{1'b0}}, off_ff};
   assign row_ext = {{ROW_W{1'b0}}, row_ff};
   assign col_ext = {{COL_W{1'b0}}, col_ff};

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_cursor_offset = off_ext[OFFSET_W-1:0];
   assign rsp_cursor_row    = row_ext[ROW_W-1:0];
   assign rsp_cursor_col    = col_ext[COL_W-1:0];
   assign rsp_scrolled      = scrolled_ff;
   assign rsp_cell_char     = rdok_ff ? rd_data_ff[CHAR_W-1:0] : '0;
   assign rsp_cell_attr     = rdok_ff ? rd_data_ff[CELL_W-1:CHAR_W] : '0;

   // A response word never appears while the store walk is still running.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // The cursor row never passes the last row between requests.
   assert property (@(posedge clock) disable iff (reset) row_ff <= LAST_ROW)
      else $error("cursor row beyond last row");

   // The tracked linear offset always agrees with row and column.
   assert property (@(posedge clock) disable iff (reset)
      int'(off_ff) == int'(row_ff) * COL_COUNT + int'(col_ff))
      else $error("cursor offset out of step with row and column");

   // A clear always starts a walk over the store.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == REQ_CLEAR)) |=> busy)
      else $error("clear did not start a store walk");

endmodule
